FILE: rtl/b64e_pkg.sv
package b64e_pkg;

    // depth of the job queue between front and back
    localparam int JOBQ_DEPTH = 2;
    // depth of the character queue at the result ports
    localparam int OUTQ_DEPTH = 2;
    // most characters one byte can produce
    localparam int MAX_CHARS = 4;

    localparam logic [7:0] PAD_CHAR      = 8'h3D;
    localparam logic [7:0] SYM62_RESET   = 8'd43;
    localparam logic [7:0] SYM63_RESET   = 8'd47;
    localparam logic       PAD_EN_RESET  = 1'b1;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_SYMBOL_62  = 2'd0,
        CFG_SYMBOL_63  = 2'd1,
        CFG_PAD_ENABLE = 2'd2,
        CFG_UNUSED     = 2'd3
    } cfg_idx_t;

    // one output character before alphabet lookup
    typedef struct packed {
        logic       pad;
        logic [5:0] val;
    } sym_t;

    // all characters produced by one input byte
    typedef struct packed {
        logic [2:0]                 count;
        logic                       last;
        sym_t [MAX_CHARS-1:0]       sym;
    } job_t;

    // configuration values shared by front and back
    typedef struct packed {
        logic [7:0] symbol_62;
        logic [7:0] symbol_63;
        logic       pad_enable;
    } cfg_t;

    // six-bit value to alphabet character
    function automatic logic [7:0] map_symbol(
        input logic [5:0] v,
        input logic [7:0] s62,
        input logic [7:0] s63
    );
        logic [7:0] r;
        logic [7:0] ve;
        ve = {2'b00, v};
        if (v < 6'd26)
            r = 8'd65 + ve;
        else if (v < 6'd52)
            r = 8'd71 + ve;
        else if (v < 6'd62)
            r = ve - 8'd4;
        else if (v == 6'd62)
            r = s62;
        else
            r = s63;
        return r;
    endfunction

endpackage

FILE: rtl/b64e_front.sv
module b64e_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic [7:0]           data_byte,
    input  logic                 final_byte,
    output logic                 full,
    input  b64e_pkg::cfg_t       cfg,
    input  logic                 jobq_full,
    output logic                 jobq_push,
    output b64e_pkg::job_t       jobq_data
);

    logic [1:0] phase_reg, phase_next;
    logic [3:0] left_reg, left_next;
    logic       accept;

    assign full   = jobq_full;
    assign accept = push && !jobq_full;
    assign jobq_push = accept;

    // split the byte into six-bit symbols for its group position
    always_comb
    begin
        jobq_data = '0;
        jobq_data.last = final_byte;
        phase_next = phase_reg;
        left_next  = left_reg;
        case (phase_reg)
            2'd1:
            begin
                jobq_data.sym[0].val = {left_reg[1:0], data_byte[7:4]};
                jobq_data.sym[1].val = {data_byte[3:0], 2'b00};
                jobq_data.sym[2].pad = 1'b1;
                if (final_byte)
                    jobq_data.count = cfg.pad_enable ? 3'd3 : 3'd2;
                else
                    jobq_data.count = 3'd1;
                phase_next = 2'd2;
                left_next  = data_byte[3:0];
            end
            2'd2:
            begin
                jobq_data.sym[0].val = {left_reg, data_byte[7:6]};
                jobq_data.sym[1].val = data_byte[5:0];
                jobq_data.count = 3'd2;
                phase_next = 2'd0;
                left_next  = 4'd0;
            end
            default:
            begin
                // phase 0, and the unreachable phase 3 taken the same way
                jobq_data.sym[0].val = data_byte[7:2];
                jobq_data.sym[1].val = {data_byte[1:0], 4'b0000};
                jobq_data.sym[2].pad = 1'b1;
                jobq_data.sym[3].pad = 1'b1;
                if (final_byte)
                    jobq_data.count = cfg.pad_enable ? 3'd4 : 3'd2;
                else
                    jobq_data.count = 3'd1;
                phase_next = 2'd1;
                left_next  = {2'b00, data_byte[1:0]};
            end
        endcase
        if (final_byte)
        begin
            phase_next = 2'd0;
            left_next  = 4'd0;
        end
    end

    // group position and carried bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 2'd0;
            left_reg  <= 4'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
        end
    end

endmodule

FILE: rtl/b64e_jobq.sv
module b64e_jobq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  b64e_pkg::job_t       wr_data,
    output logic                 full,
    input  logic                 rd_en,
    output b64e_pkg::job_t       rd_data,
    output logic                 empty
);

    localparam int PW = (b64e_pkg::JOBQ_DEPTH > 1) ? $clog2(b64e_pkg::JOBQ_DEPTH) : 1;
    localparam int CW = $clog2(b64e_pkg::JOBQ_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(b64e_pkg::JOBQ_DEPTH);
    localparam logic [PW-1:0] LAST_C  = PW'(b64e_pkg::JOBQ_DEPTH - 1);

    b64e_pkg::job_t mem_reg [b64e_pkg::JOBQ_DEPTH];
    logic [PW-1:0] wptr_reg, rptr_reg;
    logic [CW-1:0] cnt_reg;
    logic          do_wr, do_rd;

    assign empty   = (cnt_reg == '0);
    assign do_rd   = rd_en && !empty;
    // a slot freed by a read this cycle may be refilled at once
    assign full    = (cnt_reg == DEPTH_C) && !do_rd;
    assign do_wr   = wr_en && !full;
    assign rd_data = mem_reg[rptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wptr_reg] <= wr_data;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wptr_reg <= (wptr_reg == LAST_C) ? '0 : wptr_reg + 1'b1;
            if (do_rd)
                rptr_reg <= (rptr_reg == LAST_C) ? '0 : rptr_reg + 1'b1;
            if (do_wr && !do_rd)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_rd && !do_wr)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

FILE: rtl/b64e_back.sv
module b64e_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  b64e_pkg::cfg_t       cfg,
    input  b64e_pkg::job_t       job,
    input  logic                 job_empty,
    output logic                 job_pop,
    output logic [7:0]           text_char,
    output logic                 end_of_text,
    output logic                 empty,
    input  logic                 pop
);

    localparam int PW = (b64e_pkg::OUTQ_DEPTH > 1) ? $clog2(b64e_pkg::OUTQ_DEPTH) : 1;
    localparam int CW = $clog2(b64e_pkg::OUTQ_DEPTH + 1);
    localparam int IW = $clog2(b64e_pkg::MAX_CHARS);
    localparam logic [CW-1:0] DEPTH_C = CW'(b64e_pkg::OUTQ_DEPTH);
    localparam logic [PW-1:0] LAST_C  = PW'(b64e_pkg::OUTQ_DEPTH - 1);

    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
    } oq_entry_t;

    oq_entry_t     oq_reg [b64e_pkg::OUTQ_DEPTH];
    logic [PW-1:0] wptr_reg, rptr_reg;
    logic [CW-1:0] cnt_reg;
    logic [IW-1:0] idx_reg;
    logic [IW-1:0] last_idx;
    b64e_pkg::sym_t cur;
    oq_entry_t     new_entry;
    logic          do_rd, oq_room, emit, last_char;

    // pick the next character of the head job
    assign cur       = job.sym[idx_reg];
    assign last_idx  = IW'(job.count - 3'd1);
    assign last_char = (idx_reg == last_idx);

    always_comb
    begin
        new_entry.ch  = cur.pad ? b64e_pkg::PAD_CHAR
                      : b64e_pkg::map_symbol(cur.val, cfg.symbol_62, cfg.symbol_63);
        new_entry.eot = job.last && last_char;
    end

    // output queue handshake
    assign empty   = (cnt_reg == '0);
    assign do_rd   = pop && !empty;
    assign oq_room = (cnt_reg != DEPTH_C) || do_rd;
    assign emit    = !job_empty && oq_room;
    assign job_pop = emit && last_char;

    assign text_char   = oq_reg[rptr_reg].ch;
    assign end_of_text = oq_reg[rptr_reg].eot;

    // character storage
    always_ff @(posedge clk)
    begin
        if (emit)
            oq_reg[wptr_reg] <= new_entry;
    end

    // serializer index, pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (emit)
                idx_reg <= last_char ? '0 : idx_reg + 1'b1;
            if (emit)
                wptr_reg <= (wptr_reg == LAST_C) ? '0 : wptr_reg + 1'b1;
            if (do_rd)
                rptr_reg <= (rptr_reg == LAST_C) ? '0 : rptr_reg + 1'b1;
            if (emit && !do_rd)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_rd && !emit)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // checks
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= DEPTH_C)
        else $error("output queue count overflow");

    a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
        !job_empty |-> ({1'b0, idx_reg} < job.count))
        else $error("serializer index beyond job length");

    a_idx_rest: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |=> (idx_reg == '0))
        else $error("serializer index not cleared after job");

    a_eot_last: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && new_entry.eot) |-> job_pop)
        else $error("end of text before job finished");

endmodule

FILE: rtl/base64_stream_encoder_unit.sv
// path: a byte accepted is written into the job queue, and the serializer then writes its
//   characters into the result queue, from which the first can be popped
// throughput: one character per cycle into the result queue while it has room, one to four per byte;
//   a byte enters every cycle while the job queue has room, so the sustained
//   byte rate is set by the single character per cycle of the output serializer
// reset: asynchronous, clears group position, carried bits and both queues, and
//   loads symbol_62 '+', symbol_63 '/' and pad_enable 1
module base64_stream_encoder_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] data_byte,
    input  logic       final_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] text_char,
    output logic       end_of_text,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    b64e_pkg::cfg_t cfg_reg;
    b64e_pkg::job_t enq_job, head_job;
    logic           enq, jq_full, jq_empty, deq;

    // configuration registers, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.symbol_62  <= b64e_pkg::SYM62_RESET;
            cfg_reg.symbol_63  <= b64e_pkg::SYM63_RESET;
            cfg_reg.pad_enable <= b64e_pkg::PAD_EN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (b64e_pkg::cfg_idx_t'(cfg_index))
                b64e_pkg::CFG_SYMBOL_62:  cfg_reg.symbol_62  <= cfg_data;
                b64e_pkg::CFG_SYMBOL_63:  cfg_reg.symbol_63  <= cfg_data;
                b64e_pkg::CFG_PAD_ENABLE: cfg_reg.pad_enable <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // byte classification
    b64e_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .full       (full),
        .cfg        (cfg_reg),
        .jobq_full  (jq_full),
        .jobq_push  (enq),
        .jobq_data  (enq_job)
    );

    // jobs between front and back
    b64e_jobq u_jobq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (enq),
        .wr_data (enq_job),
        .full    (jq_full),
        .rd_en   (deq),
        .rd_data (head_job),
        .empty   (jq_empty)
    );

    // character serializer and result queue
    b64e_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .job         (head_job),
        .job_empty   (jq_empty),
        .job_pop     (deq),
        .text_char   (text_char),
        .end_of_text (end_of_text),
        .empty       (empty),
        .pop         (pop)
    );

endmodule
